@@ rtl/core/tked_pkg.sv @@
// Package: types and constants for the terminal key escape decoder.
`default_nettype none

package tked_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_LEAD  = 3'd2,
    PH_DIGIT = 3'd3,
    PH_SEMI  = 3'd4,
    PH_PARAM = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] lead_byte;
    logic [7:0] digit_byte;
    logic       param_is_five;
  } dec_state_t;

  typedef struct packed {
    logic       vld;
    logic [3:0] key_kind;
    logic [7:0] key_byte;
  } dec_result_t;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;
  localparam logic [7:0] BYTE_SS3   = 8'h4F;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_FIVE  = 8'h35;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] BYTE_ONE   = 8'h31;
  localparam logic [7:0] BYTE_THREE = 8'h33;
  localparam logic [7:0] BYTE_FOUR  = 8'h34;
  localparam logic [7:0] BYTE_SIX   = 8'h36;
  localparam logic [7:0] BYTE_SEVEN = 8'h37;
  localparam logic [7:0] BYTE_EIGHT = 8'h38;
  localparam logic [7:0] BYTE_A     = 8'h41;
  localparam logic [7:0] BYTE_B     = 8'h42;
  localparam logic [7:0] BYTE_C     = 8'h43;
  localparam logic [7:0] BYTE_D     = 8'h44;
  localparam logic [7:0] BYTE_H     = 8'h48;
  localparam logic [7:0] BYTE_F     = 8'h46;

  localparam logic [3:0] KIND_PLAIN  = 4'd0;
  localparam logic [3:0] KIND_ESC    = 4'd1;
  localparam logic [3:0] KIND_UP     = 4'd2;
  localparam logic [3:0] KIND_DOWN   = 4'd3;
  localparam logic [3:0] KIND_RIGHT  = 4'd4;
  localparam logic [3:0] KIND_LEFT   = 4'd5;
  localparam logic [3:0] KIND_HOME   = 4'd6;
  localparam logic [3:0] KIND_END    = 4'd7;
  localparam logic [3:0] KIND_DEL    = 4'd8;
  localparam logic [3:0] KIND_PGUP   = 4'd9;
  localparam logic [3:0] KIND_PGDN   = 4'd10;
  localparam logic [3:0] KIND_CUP    = 4'd11;
  localparam logic [3:0] KIND_CDOWN  = 4'd12;
  localparam logic [3:0] KIND_CRIGHT = 4'd13;
  localparam logic [3:0] KIND_CLEFT  = 4'd14;

endpackage

`default_nettype wire

@@ rtl/core/terminal_key_escape_decoder_unit.sv @@
// Top level: terminal key escape decoder with input and result registers.
`default_nettype none

// Decodes VT100 style key escape sequences from a byte stream, one transaction
// per clock. Each input transaction (a byte, or a timeout when in_mode is 1) is
// captured in an input register, decoded by a short combinational step against
// the sequence state, and the key, if any, lands in the result register. A key
// appears on out_* via the input register, then the result register. Throughput
// is one transaction per cycle while out_stall is low; in_stall rises only when the
// input register holds a key-producing transaction and the result register is
// full and stalled.
module terminal_key_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_key_kind,
  output logic [7:0] out_key_byte
);

  logic                  s1_valid_r;
  logic                  s1_mode_r;
  logic [7:0]            s1_byte_r;
  tked_pkg::dec_state_t  state_r;
  tked_pkg::dec_state_t  state_nxt;
  tked_pkg::dec_result_t res;
  logic                  out_free;
  logic                  advance;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [3:0]            out_kind_r;
  logic [7:0]            out_byte_r;

  tked_decode u_decode (
    .cur     (state_r),
    .mode    (s1_mode_r),
    .in_byte (s1_byte_r),
    .nxt     (state_nxt),
    .res     (res)
  );

  assign out_free      = !out_valid_r || !out_stall;
  assign advance       = s1_valid_r && (!res.vld || out_free);
  assign in_stall      = s1_valid_r && !advance;
  assign out_valid_nxt = (advance && res.vld) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= tked_pkg::PH_IDLE;
      state_r.lead_byte     <= 8'd0;
      state_r.digit_byte    <= 8'd0;
      state_r.param_is_five <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      out_kind_r <= res.key_kind;
      out_byte_r <= res.key_byte;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_kind = out_kind_r;
  assign out_key_byte = out_byte_r;

`ifndef SYNTHESIS
  a_byte_only_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_byte != 8'd0) |-> (out_key_kind == tked_pkg::KIND_PLAIN))
    else $error("nonzero key byte on a non-plain key");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_kind <= tked_pkg::KIND_CLEFT))
    else $error("key kind out of range");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && res.vld && out_valid_r && out_stall))
    else $error("input stalled without a blocked key");

  a_key_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.vld) |=> (out_valid && out_key_kind == $past(res.key_kind)))
    else $error("decoded key not captured");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tked_decode.sv @@
// Combinational escape sequence decoder: next state and result for one transaction.
`default_nettype none

module tked_decode (
  input  tked_pkg::dec_state_t  cur,
  input  logic                  mode,
  input  logic [7:0]            in_byte,
  output tked_pkg::dec_state_t  nxt,
  output tked_pkg::dec_result_t res
);

  logic is_digit;
  logic is_arrow;
  logic is_hf;

  assign is_digit = in_byte inside {[tked_pkg::BYTE_ZERO:tked_pkg::BYTE_NINE]};
  assign is_arrow = in_byte inside {[tked_pkg::BYTE_A:tked_pkg::BYTE_D]};
  assign is_hf    = in_byte inside {tked_pkg::BYTE_H, tked_pkg::BYTE_F};

  // next state
  always_comb begin
    nxt = cur;
    case (cur.phase)
      tked_pkg::PH_ESC: begin
        if (mode) begin
          nxt.phase = tked_pkg::PH_IDLE;
        end else begin
          nxt.lead_byte = in_byte;
          nxt.phase     = tked_pkg::PH_LEAD;
        end
      end
      tked_pkg::PH_LEAD: begin
        if (!mode && cur.lead_byte == tked_pkg::BYTE_CSI && is_digit) begin
          nxt.digit_byte = in_byte;
          nxt.phase      = tked_pkg::PH_DIGIT;
        end else begin
          nxt.phase = tked_pkg::PH_IDLE;
        end
      end
      tked_pkg::PH_DIGIT: begin
        if (!mode && in_byte == tked_pkg::BYTE_SEMI) begin
          nxt.phase = tked_pkg::PH_SEMI;
        end else begin
          nxt.phase = tked_pkg::PH_IDLE;
        end
      end
      tked_pkg::PH_SEMI: begin
        if (mode) begin
          nxt.phase = tked_pkg::PH_IDLE;
        end else begin
          nxt.param_is_five = (in_byte == tked_pkg::BYTE_FIVE);
          nxt.phase         = tked_pkg::PH_PARAM;
        end
      end
      tked_pkg::PH_PARAM: begin
        nxt.phase = tked_pkg::PH_IDLE;
      end
      default: begin
        if (!mode && in_byte == tked_pkg::BYTE_ESC) begin
          nxt.phase = tked_pkg::PH_ESC;
        end else begin
          nxt.phase = tked_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res.vld      = 1'b0;
    res.key_kind = tked_pkg::KIND_ESC;
    res.key_byte = 8'd0;
    if (cur.phase == tked_pkg::PH_IDLE) begin
      if (!mode && in_byte != tked_pkg::BYTE_ESC) begin
        res.vld      = 1'b1;
        res.key_kind = tked_pkg::KIND_PLAIN;
        res.key_byte = in_byte;
      end
    end else if (mode) begin
      res.vld = 1'b1;
    end else begin
      case (cur.phase)
        tked_pkg::PH_LEAD: begin
          if (!(cur.lead_byte == tked_pkg::BYTE_CSI && is_digit)) begin
            res.vld = 1'b1;
            if (cur.lead_byte == tked_pkg::BYTE_CSI && is_arrow) begin
              case (in_byte)
                tked_pkg::BYTE_A: res.key_kind = tked_pkg::KIND_UP;
                tked_pkg::BYTE_B: res.key_kind = tked_pkg::KIND_DOWN;
                tked_pkg::BYTE_C: res.key_kind = tked_pkg::KIND_RIGHT;
                default:          res.key_kind = tked_pkg::KIND_LEFT;
              endcase
            end else if ((cur.lead_byte == tked_pkg::BYTE_CSI ||
                          cur.lead_byte == tked_pkg::BYTE_SS3) && is_hf) begin
              res.key_kind = (in_byte == tked_pkg::BYTE_H) ? tked_pkg::KIND_HOME
                                                            : tked_pkg::KIND_END;
            end
          end
        end
        tked_pkg::PH_DIGIT: begin
          if (in_byte != tked_pkg::BYTE_SEMI) begin
            res.vld = 1'b1;
            if (in_byte == tked_pkg::BYTE_TILDE) begin
              case (cur.digit_byte)
                tked_pkg::BYTE_ONE,
                tked_pkg::BYTE_SEVEN: res.key_kind = tked_pkg::KIND_HOME;
                tked_pkg::BYTE_THREE: res.key_kind = tked_pkg::KIND_DEL;
                tked_pkg::BYTE_FOUR,
                tked_pkg::BYTE_EIGHT: res.key_kind = tked_pkg::KIND_END;
                tked_pkg::BYTE_FIVE:  res.key_kind = tked_pkg::KIND_PGUP;
                tked_pkg::BYTE_SIX:   res.key_kind = tked_pkg::KIND_PGDN;
                default:              res.key_kind = tked_pkg::KIND_ESC;
              endcase
            end
          end
        end
        tked_pkg::PH_PARAM: begin
          res.vld = 1'b1;
          if (cur.param_is_five && is_arrow) begin
            case (in_byte)
              tked_pkg::BYTE_A: res.key_kind = tked_pkg::KIND_CUP;
              tked_pkg::BYTE_B: res.key_kind = tked_pkg::KIND_CDOWN;
              tked_pkg::BYTE_C: res.key_kind = tked_pkg::KIND_CRIGHT;
              default:          res.key_kind = tked_pkg::KIND_CLEFT;
            endcase
          end
        end
        default: begin
          res.vld = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
